// File: design/yuyv2rgb_pkg.sv
`default_nettype none

package yuyv2rgb_pkg;

  // Component and coefficient formats
  localparam int PIX_W = 8;
  localparam int COEF_FRAC_BITS_DEF = 14;

  // Studio-swing offsets
  localparam int unsigned Y_OFFSET = 16;
  localparam int unsigned C_OFFSET = 128;

  // Exact rational scale factors, folded with the matrix coefficients
  localparam longint unsigned KY_NUM = 255;
  localparam longint unsigned KY_DEN = 219;
  localparam longint unsigned KRV_NUM = 357510;
  localparam longint unsigned KGU_NUM = 87720;
  localparam longint unsigned KGV_NUM = 182070;
  localparam longint unsigned KBU_NUM = 451860;
  localparam longint unsigned C_DEN = 224000;

  typedef struct packed {
    logic [PIX_W-1:0] luma_first;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] luma_second;
    logic [PIX_W-1:0] chroma_red;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_first;
    logic [PIX_W-1:0] green_first;
    logic [PIX_W-1:0] blue_first;
    logic [PIX_W-1:0] red_second;
    logic [PIX_W-1:0] green_second;
    logic [PIX_W-1:0] blue_second;
  } out_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

endpackage

`default_nettype wire

// File: design/yuyv2rgb_lane.sv
`default_nettype none

// One pixel lane: offset, constant multiply, sum and clamp in two stages.
module yuyv2rgb_lane #(
  parameter int COEF_FRAC_BITS = yuyv2rgb_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic [yuyv2rgb_pkg::PIX_W-1:0]  luma_i,
  input  wire logic [yuyv2rgb_pkg::PIX_W-1:0]  cb_i,
  input  wire logic [yuyv2rgb_pkg::PIX_W-1:0]  cr_i,
  output yuyv2rgb_pkg::rgb_t                   pix_o
);

  localparam int OW = yuyv2rgb_pkg::PIX_W + 1;
  localparam int CW = COEF_FRAC_BITS + 3;
  localparam int PW = CW + OW;
  localparam int SW = PW + 2;

  localparam longint unsigned KY_L =
    ((yuyv2rgb_pkg::KY_NUM << COEF_FRAC_BITS) + yuyv2rgb_pkg::KY_DEN / 2)
    / yuyv2rgb_pkg::KY_DEN;
  localparam longint unsigned KRV_L =
    ((yuyv2rgb_pkg::KRV_NUM << COEF_FRAC_BITS) + yuyv2rgb_pkg::C_DEN / 2)
    / yuyv2rgb_pkg::C_DEN;
  localparam longint unsigned KGU_L =
    ((yuyv2rgb_pkg::KGU_NUM << COEF_FRAC_BITS) + yuyv2rgb_pkg::C_DEN / 2)
    / yuyv2rgb_pkg::C_DEN;
  localparam longint unsigned KGV_L =
    ((yuyv2rgb_pkg::KGV_NUM << COEF_FRAC_BITS) + yuyv2rgb_pkg::C_DEN / 2)
    / yuyv2rgb_pkg::C_DEN;
  localparam longint unsigned KBU_L =
    ((yuyv2rgb_pkg::KBU_NUM << COEF_FRAC_BITS) + yuyv2rgb_pkg::C_DEN / 2)
    / yuyv2rgb_pkg::C_DEN;

  localparam logic signed [CW-1:0] KY_C  = CW'(KY_L);
  localparam logic signed [CW-1:0] KRV_C = CW'(KRV_L);
  localparam logic signed [CW-1:0] KGU_C = CW'(KGU_L);
  localparam logic signed [CW-1:0] KGV_C = CW'(KGV_L);
  localparam logic signed [CW-1:0] KBU_C = CW'(KBU_L);

  function automatic logic [yuyv2rgb_pkg::PIX_W-1:0] sat_ch(
    input logic signed [SW-1:0] s
  );
    logic [yuyv2rgb_pkg::PIX_W-1:0] res;
    if (s[SW-1]) begin
      res = '0;
    end else if (|s[SW-2:COEF_FRAC_BITS+yuyv2rgb_pkg::PIX_W]) begin
      res = '1;
    end else begin
      res = s[COEF_FRAC_BITS+yuyv2rgb_pkg::PIX_W-1:COEF_FRAC_BITS];
    end
    return res;
  endfunction

  logic signed [OW-1:0] ys, cbs, crs;
  logic signed [PW-1:0] yterm_r, rv_r, gu_r, gv_r, bu_r;
  logic signed [PW-1:0] yterm_nxt, rv_nxt, gu_nxt, gv_nxt, bu_nxt;
  logic signed [SW-1:0] r_sum, g_sum, b_sum;
  yuyv2rgb_pkg::rgb_t   pix_r, pix_nxt;

  // Stage 1: remove offsets and multiply by the folded constants
  assign ys  = $signed({1'b0, luma_i}) - $signed(OW'(yuyv2rgb_pkg::Y_OFFSET));
  assign cbs = $signed({1'b0, cb_i})   - $signed(OW'(yuyv2rgb_pkg::C_OFFSET));
  assign crs = $signed({1'b0, cr_i})   - $signed(OW'(yuyv2rgb_pkg::C_OFFSET));

  assign yterm_nxt = PW'(KY_C)  * PW'(ys);
  assign rv_nxt    = PW'(KRV_C) * PW'(crs);
  assign gu_nxt    = PW'(KGU_C) * PW'(cbs);
  assign gv_nxt    = PW'(KGV_C) * PW'(crs);
  assign bu_nxt    = PW'(KBU_C) * PW'(cbs);

  always_ff @(posedge clk) begin
    yterm_r <= yterm_nxt;
    rv_r    <= rv_nxt;
    gu_r    <= gu_nxt;
    gv_r    <= gv_nxt;
    bu_r    <= bu_nxt;
  end

  // Stage 2: sum the terms and clamp to 0..255
  assign r_sum = SW'(yterm_r) + SW'(rv_r);
  assign g_sum = SW'(yterm_r) - SW'(gu_r) - SW'(gv_r);
  assign b_sum = SW'(yterm_r) + SW'(bu_r);

  always_comb begin
    pix_nxt.red   = sat_ch(r_sum);
    pix_nxt.green = sat_ch(g_sum);
    pix_nxt.blue  = sat_ch(b_sum);
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

  assign pix_o = pix_r;

endmodule

`default_nettype wire

// File: design/yuyv2rgb_merge.sv
`default_nettype none

// Merge the two lane pixels into one result and drive the strobe.
module yuyv2rgb_merge (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               valid_i,
  input  wire yuyv2rgb_pkg::rgb_t pix_first_i,
  input  wire yuyv2rgb_pkg::rgb_t pix_second_i,
  output logic                    out_valid_o,
  output yuyv2rgb_pkg::out_t      out_data_o
);

  logic               valid_r;
  yuyv2rgb_pkg::out_t data_r, data_nxt;

  always_comb begin
    data_nxt.red_first    = pix_first_i.red;
    data_nxt.green_first  = pix_first_i.green;
    data_nxt.blue_first   = pix_first_i.blue;
    data_nxt.red_second   = pix_second_i.red;
    data_nxt.green_second = pix_second_i.green;
    data_nxt.blue_second  = pix_second_i.blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid_o = valid_r;
  assign out_data_o  = data_r;

endmodule

`default_nettype wire

// File: design/yuyv_to_rgb_converter_unit.sv
// YUYV 4:2:2 to RGB converter, BT.601 studio swing.
//
// Input: one macropixel (Y0, U, Y1, V) in in_data. A transaction is taken at
// a rising edge where start is high and busy is low. busy is high while reset
// is applied and stays high until the first clock edge that sees it released; otherwise a new
// macropixel can be taken every cycle, so throughput is one macropixel (two
// pixels) per clock.
// Output: one result holding two RGB pixels, shown on out_data for exactly one
// cycle with out_valid high. The receiver cannot stall; every result must be
// taken in the cycle it appears.
// Pipeline: a transaction taken at an edge passes through three register
// stages (products, clamped sums, merge) before it is on the outputs.
// Each pixel has its own lane with its own constant multipliers; the lane
// pipeline sets the latency, and nothing loops back, so the rate is one.
// Reset (synchronous, active low) clears the valid pipeline; data in flight
// is dropped and no result appears for it.
`default_nettype none

module yuyv_to_rgb_converter_unit #(
  parameter int COEF_FRAC_BITS = yuyv2rgb_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire yuyv2rgb_pkg::in_t in_data,
  output logic                   out_valid,
  output yuyv2rgb_pkg::out_t     out_data
);

  logic               busy_r;
  logic               accept;
  logic               v1_r, v2_r;
  yuyv2rgb_pkg::rgb_t pix_first, pix_second;

  // Hold off until the first edge out of reset, then accept every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // Advance the valid flags alongside the lane stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  // Even pixel lane: Y0 with the macropixel's own U and V
  yuyv2rgb_lane #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_lane_first (
    .clk    (clk),
    .luma_i (in_data.luma_first),
    .cb_i   (in_data.chroma_blue),
    .cr_i   (in_data.chroma_red),
    .pix_o  (pix_first)
  );

  // Odd pixel lane: Y1 with the same chroma
  yuyv2rgb_lane #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_lane_second (
    .clk    (clk),
    .luma_i (in_data.luma_second),
    .cb_i   (in_data.chroma_blue),
    .cr_i   (in_data.chroma_red),
    .pix_o  (pix_second)
  );

  // Combine both pixels into one result transaction
  yuyv2rgb_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid_i      (v2_r),
    .pix_first_i  (pix_first),
    .pix_second_i (pix_second),
    .out_valid_o  (out_valid),
    .out_data_o   (out_data)
  );

endmodule

`default_nettype wire

// File: design/yuyv2rgb_checker.sv
`default_nettype none

module yuyv2rgb_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire yuyv2rgb_pkg::in_t  in_data,
  input wire logic               out_valid,
  input wire yuyv2rgb_pkg::out_t out_data
);

  // Out of reset, the block accepts every cycle
  a_busy_after_reset: assert property (@(posedge clk)
    $past(rst_n) |-> !busy)
    else $error("busy high after reset released");

  // Every accepted transaction gives a result after the three register stages
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result missing for accepted transaction");

  // No result without a matching accepted transaction
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result without accepted transaction");

  // Black with neutral chroma converts to zero on every channel of the first pixel
  a_black_even: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_data.chroma_blue == 8'd128 && in_data.chroma_red == 8'd128
      && in_data.luma_first <= 8'd16, 3))
    |-> (out_data.red_first == 8'd0 && out_data.green_first == 8'd0
      && out_data.blue_first == 8'd0))
    else $error("neutral black pixel not converted to zero");

endmodule

bind yuyv_to_rgb_converter_unit yuyv2rgb_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
